/* rtl/core/gpsu_pkg.sv */
// Shared types, constants and width helpers for the GPS-time-to-UTC date converter.
package gpsu_pkg;

  // Pipeline depth: four stages of second splitting, eight of calendar math
  localparam int NUM_STAGES   = 12;
  localparam int SPLIT_STAGES = 4;

  typedef logic [NUM_STAGES-1:0] stage_en_t;

  typedef logic        [15:0] week_t;
  typedef logic        [39:0] sow_t;
  typedef logic signed [7:0]  offset_t;
  typedef logic        [11:0] year_t;
  typedef logic        [3:0]  month_t;
  typedef logic        [4:0]  day_t;
  typedef logic        [4:0]  hour_t;
  typedef logic        [5:0]  minute_t;
  typedef logic        [25:0] second_t;

  localparam offset_t OFFSET_RESET = 8'sd18;
  localparam int      SECS_PER_DAY = 86400;

  // Days from 0000-03-01 to 1970-01-01 plus days from 1970 to the GPS epoch,
  // less the one day that biases the seconds remainder positive
  localparam int DAY_BIAS = 723124;

  // Width of the fraction path; at least one bit so the vector exists
  function automatic int frac_width(int frac_bits);
    return (frac_bits > 0) ? frac_bits : 1;
  endfunction

  // Width of the biased whole-second sum inside the week
  function automatic int shift_width(int frac_bits);
    int siw;
    siw = 40 - frac_bits;
    return ((siw > 17) ? siw : 17) + 1;
  endfunction

  // Width of the day count shifted to the March-based civil epoch
  function automatic int day_width(int frac_bits);
    int qw;
    qw = shift_width(frac_bits) - 16;
    return ((qw > 21) ? qw : 21) + 1;
  endfunction

endpackage

/* rtl/core/gpsu_if.sv */
// Valid/ready channel interfaces for the GPS time input and the UTC date output.
interface gpsu_in_if;
  import gpsu_pkg::*;
  logic  valid;
  logic  ready;
  week_t week_number;
  sow_t  week_seconds;

  modport source (output valid, week_number, week_seconds, input ready);
  modport sink   (input valid, week_number, week_seconds, output ready);
endinterface

interface gpsu_out_if;
  import gpsu_pkg::*;
  logic    valid;
  logic    ready;
  year_t   year_out;
  month_t  month_out;
  day_t    day_out;
  hour_t   hour_out;
  minute_t minute_out;
  second_t second_out;

  modport source (output valid, year_out, month_out, day_out, hour_out, minute_out,
                  second_out, input ready);
  modport sink   (input valid, year_out, month_out, day_out, hour_out, minute_out,
                  second_out, output ready);
endinterface

/* rtl/core/gpsu_day_split.sv */
// Stages 1-4: form the UTC second count and split it into civil day number and second of day.
module gpsu_day_split #(
  parameter int FRAC_BITS = 20,
  localparam int FW = gpsu_pkg::frac_width(FRAC_BITS),
  localparam int ZW = gpsu_pkg::day_width(FRAC_BITS)
) (
  input  logic               clk,
  input  gpsu_pkg::stage_en_t en,
  input  gpsu_pkg::offset_t   offset,
  input  gpsu_pkg::week_t     week,
  input  gpsu_pkg::sow_t      sow,
  output logic [ZW-1:0]      z,
  output logic [16:0]        sod,
  output logic [FW-1:0]      frac
);
  import gpsu_pkg::*;

  localparam int XW  = shift_width(FRAC_BITS);
  localparam int XSW = XW - 7;
  localparam int KQ  = XSW + 10;
  localparam int QW  = XSW - 9;
  localparam int LOW = XSW / 2;
  localparam int HIW = XSW - LOW;
  localparam int PW  = 2 * XSW + 1;
  // Reciprocal of 675, exact for every XSW-bit dividend
  localparam logic [XSW:0] MQ = (XSW+1)'(((64'd1 << KQ) + 64'd674) / 64'd675);
  localparam logic [39:0]  FRAC_MASK = (40'd1 << FRAC_BITS) - 40'd1;

  logic [XW-1:0]      x1, x_next;
  logic [20:0]        wk1, wk_next;
  logic [FW-1:0]      frac1, frac2, frac3;
  logic [LOW+XSW:0]   plo2;
  logic [HIW+XSW:0]   phi2;
  logic [XSW-1:0]     xs2, xs3;
  logic [6:0]         lo7_2, lo7_3;
  logic [20:0]        wk2, wk3;
  logic [PW-1:0]      prod3;
  logic [QW-1:0]      q3;
  logic [XSW-1:0]     rem4;

  // Bias seconds-in-week by one day so subtracting the leap offset never goes negative
  always_comb begin
    x_next  = XW'(sow >> FRAC_BITS) + XW'(SECS_PER_DAY) - XW'(offset);
    wk_next = 21'(week) * 21'd7 + 21'(DAY_BIAS);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x1    <= x_next;
      wk1   <= wk_next;
      frac1 <= FW'(sow & FRAC_MASK);
    end
  end

  // Split off the factor 128 of 86400; multiply the rest by 1/675 in two halves
  always_ff @(posedge clk) begin
    if (en[1]) begin
      plo2  <= (LOW+XSW+1)'(x1[LOW+6:7]) * (LOW+XSW+1)'(MQ);
      phi2  <= (HIW+XSW+1)'(x1[XW-1:LOW+7]) * (HIW+XSW+1)'(MQ);
      xs2   <= x1[XW-1:7];
      lo7_2 <= x1[6:0];
      wk2   <= wk1;
      frac2 <= frac1;
    end
  end

  // Combine the partial products into the day quotient
  assign prod3 = (PW'(phi2) << LOW) + PW'(plo2);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      q3    <= prod3[PW-1:KQ];
      xs3   <= xs2;
      lo7_3 <= lo7_2;
      wk3   <= wk2;
      frac3 <= frac2;
    end
  end

  // Remainder gives the second of day; quotient plus week days gives the civil day
  assign rem4 = xs3 - XSW'(q3) * XSW'(675);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      sod  <= {rem4[9:0], lo7_3};
      z    <= ZW'(q3) + ZW'(wk3);
      frac <= frac3;
    end
  end

endmodule

/* rtl/core/gpsu_civil.sv */
// Stages 5-12: turn the March-based day number into proleptic Gregorian year, month, day.
module gpsu_civil #(
  parameter int FRAC_BITS = 20,
  localparam int ZW = gpsu_pkg::day_width(FRAC_BITS)
) (
  input  logic               clk,
  input  gpsu_pkg::stage_en_t en,
  input  logic [ZW-1:0]      z,
  output gpsu_pkg::year_t     year,
  output gpsu_pkg::month_t    month,
  output gpsu_pkg::day_t      day
);
  import gpsu_pkg::*;

  localparam int EW = ZW - 17;
  localparam int KE = ZW + 18;
  localparam int PE = 2 * ZW + 1;
  localparam logic [ZW:0] ME   = (ZW+1)'(((64'd1 << KE) + 64'd146096) / 64'd146097);
  localparam logic [18:0] MA   = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  localparam logic [18:0] MB   = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
  localparam logic [18:0] MY   = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam logic [9:0]  M100 = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
  localparam logic [11:0] M153 = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
  localparam logic [11:0] M5   = 12'(((64'd1 << 14) + 64'd4) / 64'd5);

  logic [PE-1:0] pe;
  logic [EW-1:0] era5, era6, era7, era8, era9, era10, era11;
  logic [ZW-1:0] z5;
  logic [17:0]   doe6, doe7, doe8, doe9;
  logic [36:0]   pa, pb, py;
  logic [6:0]    a7;
  logic [2:0]    b7;
  logic          c7;
  logic [17:0]   t8;
  logic [8:0]    yoe9, yoe10, yoe11;
  logic [18:0]   pc;
  logic [17:0]   doy_full;
  logic [8:0]    doy10, doy11;
  logic [10:0]   v11, w12;
  logic [22:0]   pm, pd;
  logic [3:0]    mp11;
  logic [8:0]    dq12;
  logic [3:0]    month_next;
  logic [11:0]   year_next;

  // Era of 400 years
  assign pe = PE'(z) * PE'(ME);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      era5 <= pe[KE+EW-1:KE];
      z5   <= z;
    end
  end

  // Day within the era
  always_ff @(posedge clk) begin
    if (en[5]) begin
      doe6 <= 18'(z5 - ZW'(era5) * ZW'(146097));
      era6 <= era5;
    end
  end

  // Leap corrections of the day of era
  assign pa = 37'(doe6) * 37'(MA);
  assign pb = 37'(doe6) * 37'(MB);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      a7   <= pa[35:29];
      b7   <= pb[36:34];
      c7   <= (doe6 == 18'd146096);
      doe7 <= doe6;
      era7 <= era6;
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      t8   <= doe7 - 18'(a7) + 18'(b7) - 18'(c7);
      doe8 <= doe7;
      era8 <= era7;
    end
  end

  // Year of era
  assign py = 37'(t8) * 37'(MY);

  always_ff @(posedge clk) begin
    if (en[8]) begin
      yoe9 <= py[35:27];
      doe9 <= doe8;
      era9 <= era8;
    end
  end

  // Day of the March-based year
  assign pc       = 19'(yoe9) * 19'(M100);
  assign doy_full = doe9 - (18'(yoe9) * 18'd365 + 18'(yoe9[8:2]) - 18'(pc[17:16]));

  always_ff @(posedge clk) begin
    if (en[9]) begin
      doy10 <= doy_full[8:0];
      yoe10 <= yoe9;
      era10 <= era9;
    end
  end

  // March-based month
  assign v11 = 11'(doy10) * 11'd5 + 11'd2;
  assign pm  = 23'(v11) * 23'(M153);

  always_ff @(posedge clk) begin
    if (en[10]) begin
      mp11  <= pm[22:19];
      doy11 <= doy10;
      yoe11 <= yoe10;
      era11 <= era10;
    end
  end

  // Day of month, January-based month and calendar year
  assign w12 = 11'(mp11) * 11'd153 + 11'd2;
  assign pd  = 23'(w12) * 23'(M5);
  assign dq12 = pd[22:14];

  always_comb begin
    month_next = (mp11 < 4'd10) ? mp11 + 4'd3 : mp11 - 4'd9;
    year_next  = 12'(era11) * 12'd400 + 12'(yoe11) + 12'(month_next <= 4'd2);
  end

  always_ff @(posedge clk) begin
    if (en[11]) begin
      day   <= 5'(doy11 - dq12 + 9'd1);
      month <= month_next;
      year  <= year_next;
    end
  end

endmodule

/* rtl/core/gpsu_tod.sv */
// Stages 5-12: split the second of day into hour, minute and fixed-point second.
module gpsu_tod #(
  parameter int FRAC_BITS = 20,
  localparam int FW = gpsu_pkg::frac_width(FRAC_BITS)
) (
  input  logic               clk,
  input  gpsu_pkg::stage_en_t en,
  input  logic [16:0]        sod,
  input  logic [FW-1:0]      frac,
  output gpsu_pkg::hour_t     hour,
  output gpsu_pkg::minute_t   minute,
  output gpsu_pkg::second_t   second
);
  import gpsu_pkg::*;

  localparam int SW = 6 + FRAC_BITS;
  localparam int DLY = 3;
  localparam logic [17:0] MH = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
  localparam logic [12:0] MM = 13'(((64'd1 << 18) + 64'd59) / 64'd60);

  logic [34:0]   ph;
  logic [24:0]   pm;
  logic [4:0]    hour5, hour6, hour7, hour8;
  logic [16:0]   sod5;
  logic [11:0]   mr6, mr7;
  logic [5:0]    minute7, minute8, sec8;
  logic [FW-1:0] frac5, frac6, frac7, frac8;
  logic [4:0]    hour_d   [DLY];
  logic [5:0]    minute_d [DLY];
  logic [5:0]    sec_d    [DLY];
  logic [FW-1:0] frac_d   [DLY];

  // Hour of day
  assign ph = 35'(sod) * 35'(MH);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      hour5 <= ph[33:29];
      sod5  <= sod;
      frac5 <= frac;
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      mr6   <= 12'(sod5 - 17'(hour5) * 17'd3600);
      hour6 <= hour5;
      frac6 <= frac5;
    end
  end

  // Minute of hour
  assign pm = 25'(mr6) * 25'(MM);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      minute7 <= pm[23:18];
      mr7     <= mr6;
      hour7   <= hour6;
      frac7   <= frac6;
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      sec8    <= 6'(mr7 - 12'(minute7) * 12'd60);
      minute8 <= minute7;
      hour8   <= hour7;
      frac8   <= frac7;
    end
  end

  // Hold the time fields until the calendar path catches up
  always_ff @(posedge clk) begin
    if (en[8]) begin
      hour_d[0]   <= hour8;
      minute_d[0] <= minute8;
      sec_d[0]    <= sec8;
      frac_d[0]   <= frac8;
    end
    for (int k = 1; k < DLY; k++) begin
      if (en[8+k]) begin
        hour_d[k]   <= hour_d[k-1];
        minute_d[k] <= minute_d[k-1];
        sec_d[k]    <= sec_d[k-1];
        frac_d[k]   <= frac_d[k-1];
      end
    end
  end

  // Place whole seconds above the kept fraction
  always_ff @(posedge clk) begin
    if (en[11]) begin
      hour   <= hour_d[DLY-1];
      minute <= minute_d[DLY-1];
      second <= 26'((SW'(sec_d[DLY-1]) << FRAC_BITS) | SW'(frac_d[DLY-1]));
    end
  end

endmodule

/* rtl/core/gps_week_seconds_to_utc_date_top.sv */
// Top level: GPS week and seconds-of-week to UTC calendar date and time of day.
//
//  channel    dir  handshake     payload
//  gps_time   in   valid/ready   week_number[15:0], week_seconds[39:0] (FRAC_BITS fraction)
//  utc_date   out  valid/ready   year/month/day, hour/minute, second_out[25:0] (fixed point)
//  cfg        in   cfg_we        cfg_wdata[7:0]: GPS-UTC leap seconds, signed
//
// Twelve register stages; one item is accepted per cycle while the output is not stalled.
// Each stage keeps its own valid bit; the last stage is the output register.
// Reset clears every valid bit and loads the leap-second offset with 18.
// A stall at the output holds the last stage; earlier items keep moving into
// empty stages, so input ready drops only when the whole pipeline is full.
module gps_week_seconds_to_utc_date_top #(
  parameter int FRAC_BITS = 20
) (
  input logic             clk,
  input logic             rst,
  gpsu_in_if.sink         gps_time,
  gpsu_out_if.source      utc_date,
  input logic             cfg_we,
  input logic [7:0]       cfg_wdata
);
  import gpsu_pkg::*;

  localparam int FW = frac_width(FRAC_BITS);
  localparam int ZW = day_width(FRAC_BITS);

  offset_t             gps_utc_offset;
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] vld_in;
  logic [NUM_STAGES:0]   rdy;
  stage_en_t           en;
  logic [ZW-1:0]       z;
  logic [16:0]         sod;
  logic [FW-1:0]       frac;

  // Leap-second register
  always_ff @(posedge clk) begin
    if (rst) begin
      gps_utc_offset <= OFFSET_RESET;
    end else if (cfg_we) begin
      gps_utc_offset <= offset_t'(cfg_wdata);
    end
  end

  // A stage loads when it is empty or its successor moves
  always_comb begin
    rdy[NUM_STAGES] = utc_date.ready;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      rdy[i] = ~vld[i] | rdy[i+1];
    end
  end

  assign en     = rdy[NUM_STAGES-1:0];
  assign vld_in = {vld[NUM_STAGES-2:0], gps_time.valid};

  // Advance valid bits with their data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (en & vld_in) | (~en & vld);
    end
  end

  assign gps_time.ready = rdy[0];
  assign utc_date.valid = vld[NUM_STAGES-1];

  gpsu_day_split #(.FRAC_BITS(FRAC_BITS)) u_day_split (
    .clk    (clk),
    .en     (en),
    .offset (gps_utc_offset),
    .week   (gps_time.week_number),
    .sow    (gps_time.week_seconds),
    .z      (z),
    .sod    (sod),
    .frac   (frac)
  );

  gpsu_civil #(.FRAC_BITS(FRAC_BITS)) u_civil (
    .clk   (clk),
    .en    (en),
    .z     (z),
    .year  (utc_date.year_out),
    .month (utc_date.month_out),
    .day   (utc_date.day_out)
  );

  gpsu_tod #(.FRAC_BITS(FRAC_BITS)) u_tod (
    .clk    (clk),
    .en     (en),
    .sod    (sod),
    .frac   (frac),
    .hour   (utc_date.hour_out),
    .minute (utc_date.minute_out),
    .second (utc_date.second_out)
  );

  // An empty output register never blocks the input
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !utc_date.valid |-> gps_time.ready)
    else $error("input stalled while output register empty");

  // An accepted item occupies the first stage on the next cycle
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    gps_time.valid && gps_time.ready |=> vld[0])
    else $error("accepted item lost at first stage");

  // Calendar fields stay in range
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    utc_date.valid |-> (utc_date.month_out >= 4'd1 && utc_date.month_out <= 4'd12 &&
                        utc_date.day_out >= 5'd1))
    else $error("month or day out of range");

  // Time of day stays in range
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    utc_date.valid |-> (utc_date.hour_out <= 5'd23 && utc_date.minute_out <= 6'd59))
    else $error("hour or minute out of range");

endmodule
